// ===== hdl/dtrie_pkg.sv =====
package dtrie_pkg;

    localparam int unsigned RADIX = 10;
    localparam int unsigned DIGIT_BITS = 4;
    localparam int unsigned KEY_PORT_BITS = 40;
    localparam int unsigned HANDLE_PORT_BITS = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POOL_FULL = 3'd4,
        ST_BAD_KEY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LEAF,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t                     status;
        logic [HANDLE_PORT_BITS-1:0] found;
    } res_t;

endpackage

// ===== hdl/dtrie_ram.sv =====
module dtrie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dtrie_walker.sv =====
module dtrie_walker
    import dtrie_pkg::*;
#(
    parameter int NODE_COUNT = 4096,
    parameter int KEY_DIGITS = 10,
    parameter int HANDLE_BITS = 16,
    parameter int NODE_BITS = $clog2(NODE_COUNT),
    parameter int ROW_W = RADIX * NODE_BITS + 1 + HANDLE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        kind,
    input  logic [KEY_PORT_BITS-1:0]    key_digits,
    input  logic [HANDLE_PORT_BITS-1:0] record_handle,
    output logic                        res_valid,
    output res_t                        res,
    input  logic                        res_take,
    output logic                        rd_en,
    output logic [NODE_BITS-1:0]        rd_addr,
    input  logic [ROW_W-1:0]            rd_data,
    output logic                        wr_en,
    output logic [NODE_BITS-1:0]        wr_addr,
    output logic [ROW_W-1:0]            wr_data
);

    localparam int KEY_BITS = DIGIT_BITS * KEY_DIGITS;
    localparam int LINK_W = RADIX * NODE_BITS;
    localparam int LVL_BITS = $clog2(KEY_DIGITS + 1);
    localparam int FREE_BITS = $clog2(NODE_COUNT + 1);

    state_t                  state_reg, state_next;
    logic                    kind_reg, kind_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [HANDLE_BITS-1:0]  handle_reg, handle_next;
    logic [LVL_BITS-1:0]     level_reg, level_next;
    logic [NODE_BITS-1:0]    node_reg, node_next;
    logic                    fresh_reg, fresh_next;
    logic                    root_live_reg, root_live_next;
    logic [FREE_BITS-1:0]    free_reg, free_next;
    status_t                 status_reg, status_next;
    logic [HANDLE_PORT_BITS-1:0] found_reg, found_next;

    logic [KEY_BITS+KEY_PORT_BITS-1:0]        key_ext;
    logic [KEY_BITS-1:0]                      key_in;
    logic [HANDLE_BITS+HANDLE_PORT_BITS-1:0]  handle_ext;
    logic [HANDLE_BITS+HANDLE_PORT_BITS-1:0]  stored_ext;
    logic                    key_bad;
    logic [LINK_W-1:0]       row_links;
    logic [LINK_W-1:0]       links_ins;
    logic                    row_valid;
    logic [HANDLE_BITS-1:0]  row_handle;
    logic [DIGIT_BITS-1:0]   digit;
    logic [NODE_BITS-1:0]    link;
    logic [NODE_BITS-1:0]    new_node;
    logic [NODE_BITS-1:0]    child;
    logic                    link_null;
    logic                    pool_empty;
    logic                    last_level;
    logic                    walk_stop;

    assign key_ext = {{KEY_BITS{1'b0}}, key_digits};
    assign key_in = key_ext[KEY_BITS-1:0];
    assign handle_ext = {{HANDLE_BITS{1'b0}}, record_handle};

    always_comb
    begin
        key_bad = 1'b0;
        for (int d = 0; d < KEY_DIGITS; d++)
        begin
            if (key_in[d*DIGIT_BITS +: DIGIT_BITS] > DIGIT_BITS'(RADIX - 1))
            begin
                key_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        row_links = fresh_reg ? '0 : rd_data[LINK_W-1:0];
        row_valid = fresh_reg ? 1'b0 : rd_data[ROW_W-1];
        row_handle = rd_data[ROW_W-2 -: HANDLE_BITS];
        stored_ext = {{HANDLE_PORT_BITS{1'b0}}, row_handle};
        digit = key_reg[KEY_BITS-1 -: DIGIT_BITS];
        new_node = free_reg[NODE_BITS-1:0];
        link = '0;
        links_ins = row_links;
        for (int s = 0; s < RADIX; s++)
        begin
            if (digit == DIGIT_BITS'(s))
            begin
                link = row_links[s*NODE_BITS +: NODE_BITS];
                links_ins[s*NODE_BITS +: NODE_BITS] = new_node;
            end
        end
        link_null = (link == '0);
        pool_empty = (free_reg == FREE_BITS'(NODE_COUNT));
        child = link_null ? new_node : link;
        last_level = (level_reg == LVL_BITS'(KEY_DIGITS - 1));
        walk_stop = link_null && ((kind_reg == KIND_LOOKUP) || pool_empty);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = key_bad ? S_RESP : S_WALK;
                end
            end
            S_WALK:
            begin
                priority if (walk_stop)
                begin
                    state_next = S_RESP;
                end
                else if (last_level)
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next = kind_reg;
        key_next = key_reg;
        handle_next = handle_reg;
        level_next = level_reg;
        node_next = node_reg;
        fresh_next = fresh_reg;
        root_live_next = root_live_reg;
        free_next = free_reg;
        status_next = status_reg;
        found_next = found_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = node_reg;
        wr_data = {1'b0, {HANDLE_BITS{1'b0}}, row_links};
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = kind;
                    key_next = key_in;
                    handle_next = handle_ext[HANDLE_BITS-1:0];
                    level_next = '0;
                    node_next = '0;
                    fresh_next = !root_live_reg;
                    found_next = '0;
                    if (key_bad)
                    begin
                        status_next = ST_BAD_KEY;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
            end
            S_WALK:
            begin
                if (walk_stop)
                begin
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = ST_POOL_FULL;
                        wr_en = fresh_reg;
                    end
                end
                else
                begin
                    if (link_null)
                    begin
                        wr_en = 1'b1;
                        wr_data = {1'b0, {HANDLE_BITS{1'b0}}, links_ins};
                        free_next = free_reg + FREE_BITS'(1);
                    end
                    fresh_next = link_null;
                    node_next = child;
                    rd_en = 1'b1;
                    rd_addr = child;
                    key_next = key_reg << DIGIT_BITS;
                    level_next = level_reg + LVL_BITS'(1);
                end
                if (wr_en && (node_reg == '0))
                begin
                    root_live_next = 1'b1;
                end
            end
            S_LEAF:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    if (row_valid)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_data = {1'b1, handle_reg, {LINK_W{1'b0}}};
                        status_next = ST_INSERTED;
                    end
                end
                else if (row_valid)
                begin
                    status_next = ST_FOUND;
                    found_next = stored_ext[HANDLE_PORT_BITS-1:0];
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_live_reg <= 1'b0;
            free_reg <= FREE_BITS'(1);
            fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            root_live_reg <= root_live_next;
            free_reg <= free_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        key_reg <= key_next;
        handle_reg <= handle_next;
        level_reg <= level_next;
        node_reg <= node_next;
        status_reg <= status_next;
        found_reg <= found_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res.found = found_reg;

endmodule

// ===== hdl/decimal_digit_trie_insert_lookup_unit.sv =====
// Inserts or looks up ten-digit packed BCD keys in a fixed-depth decimal trie.
// Each trie node is one row of a single node memory that holds its ten child
// links and its leaf mark, so a request walks the key one digit per cycle, with
// one row read and at most one row write in each of those cycles. A request that
// walks every level passes from the walk states through the leaf state to the
// response state, where its response is offered. A lookup that meets a missing
// link or an insert that finds the pool full is done sooner, and a request with
// a non-digit nibble goes straight to the response state. A response still
// stalled in the output register holds the next one back for as long as it
// waits. The next request is taken as soon as the walk of the current one has
// handed its response to the output register, even while that response is still
// stalled. The node pool needs no clearing after reset; the block accepts
// requests from the first cycle after reset is released.
module decimal_digit_trie_insert_lookup_unit
    import dtrie_pkg::*;
#(
    parameter int NODE_COUNT = 4096,
    parameter int KEY_DIGITS = 10,
    parameter int HANDLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        kind,
    input  logic [KEY_PORT_BITS-1:0]    key_digits,
    input  logic [HANDLE_PORT_BITS-1:0] record_handle,
    output logic                        resp_valid,
    input  logic                        resp_stall,
    output logic [2:0]                  status,
    output logic [HANDLE_PORT_BITS-1:0] found_handle
);

    localparam int NODE_BITS = $clog2(NODE_COUNT);
    localparam int ROW_W = RADIX * NODE_BITS + 1 + HANDLE_BITS;

    logic                        res_valid;
    res_t                        res;
    logic                        res_take;
    logic                        rd_en;
    logic [NODE_BITS-1:0]        rd_addr;
    logic [ROW_W-1:0]            rd_data;
    logic                        wr_en;
    logic [NODE_BITS-1:0]        wr_addr;
    logic [ROW_W-1:0]            wr_data;
    logic                        resp_valid_reg, resp_valid_next;
    res_t                        resp_reg, resp_next;

    dtrie_walker #(
        .NODE_COUNT  (NODE_COUNT),
        .KEY_DIGITS  (KEY_DIGITS),
        .HANDLE_BITS (HANDLE_BITS),
        .NODE_BITS   (NODE_BITS),
        .ROW_W       (ROW_W)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .kind          (kind),
        .key_digits    (key_digits),
        .record_handle (record_handle),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    dtrie_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign res_take = res_valid && (!resp_valid_reg || !resp_stall);

    always_comb
    begin
        resp_valid_next = resp_valid_reg;
        resp_next = resp_reg;
        priority if (res_take)
        begin
            resp_valid_next = 1'b1;
            resp_next = res;
        end
        else if (!resp_stall)
        begin
            resp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    assign resp_valid = resp_valid_reg;
    assign status = resp_reg.status;
    assign found_handle = resp_reg.found;

endmodule

// ===== hdl/dtrie_checker.sv =====
module dtrie_checker
    import dtrie_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_stall,
    input logic                        resp_valid,
    input logic                        resp_stall,
    input logic [2:0]                  status,
    input logic [HANDLE_PORT_BITS-1:0] found_handle
);

    // A request is worked on alone, so the input closes right after taking one.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another was in progress");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && resp_stall) |=> (resp_valid && $stable(status)
            && $stable(found_handle)))
        else $error("stalled response changed or dropped");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid |-> (status <= 3'(ST_BAD_KEY)))
        else $error("response carries an undefined status");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && (status != 3'(ST_FOUND))) |-> (found_handle == '0))
        else $error("handle shown on a response that found nothing");

endmodule

bind decimal_digit_trie_insert_lookup_unit dtrie_checker u_dtrie_checker (.*);
